// ===== design/sha256_stream_hash_top_assert.svh =====
// Assertion macros shared by the SHA-256 stream hash RTL.
// Relies on clk and rst_n being visible where a macro is used.
`ifndef SHA256_STREAM_HASH_TOP_ASSERT_SVH
`define SHA256_STREAM_HASH_TOP_ASSERT_SVH
`ifndef SYNTH
`define SHS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SHS_ASSERT_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SHS_ASSERT(name, prop, msg)
`define SHS_ASSERT_NEVER(name, cond, msg)
`endif
`endif

// ===== design/sha256_pkg.sv =====
// Shared types, constants and tables for the SHA-256 stream hash.
// No dependencies.
package sha256_pkg;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_FILL = 6'd56;
    localparam logic [5:0] FILL_LAST = 6'd63;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [1:0] PART_LAST = 2'd3;

    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } msg_item_t;

    typedef struct packed {
        logic [63:0] digest_part;
        logic [1:0]  part_index;
        logic        last_part;
    } digest_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_UPDATE,
        ST_PAD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic       push_in;    // take the request byte
        logic       push_pad;   // take the next padding byte
        logic       load_vars;  // working vars <= hash words
        logic       round;      // one compression round
        logic [5:0] round_idx;
        logic       update;     // hash words += working vars
        logic       clear;      // back to reset values
        logic [1:0] part;
    } dp_cmd_t;

    typedef struct packed {
        logic fill_last;  // store holds 63 bytes
        logic len_byte;   // current pad byte is a length byte
    } dp_status_t;

endpackage

// ===== design/sha256_dp.sv =====
// SHA-256 datapath: byte packing, message schedule window, round logic,
// hash words and padding byte generation. Uses sha256_pkg.
module sha256_dp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [7:0]                data_byte,
    input  sha256_pkg::dp_cmd_t       cmd,
    output sha256_pkg::dp_status_t    status,
    output sha256_pkg::digest_item_t  digest
);

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [23:0] acc_reg;
    logic [5:0]  fill_reg;
    logic [63:0] len_reg;
    logic        pad_started_reg;
    logic        len_phase_reg;

    logic        push;
    logic        len_sel;
    logic [63:0] len_bits;
    logic [7:0]  pad_byte;
    logic [7:0]  push_byte;
    logic [31:0] w_new;
    logic [31:0] t1;
    logic [31:0] t2;

    assign push     = cmd.push_in | cmd.push_pad;
    assign len_sel  = pad_started_reg & (len_phase_reg | (fill_reg == sha256_pkg::LEN_FILL));
    assign len_bits = {len_reg[60:0], 3'b000};

    always_comb
    begin
        if (!pad_started_reg)
            pad_byte = sha256_pkg::PAD_BYTE;
        else if (len_sel)
            pad_byte = len_bits[{~fill_reg[2:0], 3'b000} +: 8];
        else
            pad_byte = 8'h00;
        push_byte = cmd.push_in ? data_byte : pad_byte;
    end

    always_comb
    begin
        w_new = w_reg[0]
              + (rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3))
              + w_reg[9]
              + (rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10));
        t1 = v_reg[7]
           + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + sha256_pkg::K_TABLE[cmd.round_idx]
           + w_reg[0];
        t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    // control state and hash words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                h_reg[i] <= sha256_pkg::H_INIT[i];
            fill_reg        <= '0;
            len_reg         <= '0;
            pad_started_reg <= 1'b0;
            len_phase_reg   <= 1'b0;
        end
        else if (cmd.clear)
        begin
            for (int i = 0; i < 8; i++)
                h_reg[i] <= sha256_pkg::H_INIT[i];
            fill_reg        <= '0;
            len_reg         <= '0;
            pad_started_reg <= 1'b0;
            len_phase_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.update)
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= h_reg[i] + v_reg[i];
            if (push)
                fill_reg <= fill_reg + 6'd1;
            if (cmd.push_in)
                len_reg <= len_reg + 64'd1;
            if (cmd.push_pad)
            begin
                if (!pad_started_reg)
                    pad_started_reg <= 1'b1;
                else if (len_sel)
                    len_phase_reg <= 1'b1;
            end
        end
    end

    // payload: schedule window, byte packer, working variables
    always_ff @(posedge clk)
    begin
        if (push)
            acc_reg <= {acc_reg[15:0], push_byte};
        if ((push && (fill_reg[1:0] == 2'd3)) || cmd.round)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= cmd.round ? w_new : {acc_reg, push_byte};
        end
        if (cmd.load_vars)
        begin
            for (int i = 0; i < 8; i++)
                v_reg[i] <= h_reg[i];
        end
        else if (cmd.round)
        begin
            v_reg[0] <= t1 + t2;
            v_reg[1] <= v_reg[0];
            v_reg[2] <= v_reg[1];
            v_reg[3] <= v_reg[2];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[5] <= v_reg[4];
            v_reg[6] <= v_reg[5];
            v_reg[7] <= v_reg[6];
        end
    end

    assign status.fill_last  = (fill_reg == sha256_pkg::FILL_LAST);
    assign status.len_byte   = len_sel;

    assign digest.digest_part = {h_reg[{cmd.part, 1'b0}], h_reg[{cmd.part, 1'b1}]};
    assign digest.part_index  = cmd.part;
    assign digest.last_part   = (cmd.part == sha256_pkg::PART_LAST);

endmodule

// ===== design/sha256_ctrl.sv =====
// SHA-256 controller: sequences byte intake, rounds, padding and the
// four digest results. Uses sha256_pkg and the assertion macro header.
`include "sha256_stream_hash_top_assert.svh"

module sha256_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    msg_valid,
    output logic                    msg_ready,
    input  logic                    has_byte,
    input  logic                    end_of_message,
    output logic                    digest_valid,
    input  logic                    digest_ready,
    input  sha256_pkg::dp_status_t  status,
    output sha256_pkg::dp_cmd_t     cmd
);

    sha256_pkg::state_t state_reg, state_next;
    logic [5:0] round_reg, round_next;
    logic [1:0] part_reg, part_next;
    logic       end_pending_reg, end_pending_next;
    logic       final_reg, final_next;
    logic       accept;

    assign accept = msg_valid & msg_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                if (msg_valid)
                begin
                    if (has_byte && status.fill_last)
                        state_next = sha256_pkg::ST_ROUND;
                    else if (end_of_message)
                        state_next = sha256_pkg::ST_PAD;
                end
            end
            sha256_pkg::ST_ROUND:
                if (round_reg == sha256_pkg::ROUND_LAST)
                    state_next = sha256_pkg::ST_UPDATE;
            sha256_pkg::ST_UPDATE:
            begin
                priority if (final_reg)
                    state_next = sha256_pkg::ST_OUT;
                else if (end_pending_reg)
                    state_next = sha256_pkg::ST_PAD;
                else
                    state_next = sha256_pkg::ST_IDLE;
            end
            sha256_pkg::ST_PAD:
                if (status.fill_last)
                    state_next = sha256_pkg::ST_ROUND;
            sha256_pkg::ST_OUT:
                if (digest_ready && (part_reg == sha256_pkg::PART_LAST))
                    state_next = sha256_pkg::ST_IDLE;
            default:
                state_next = sha256_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        msg_ready     = (state_reg == sha256_pkg::ST_IDLE);
        digest_valid  = (state_reg == sha256_pkg::ST_OUT);
        cmd.push_in   = accept & has_byte;
        cmd.push_pad  = (state_reg == sha256_pkg::ST_PAD);
        cmd.load_vars = (cmd.push_in | cmd.push_pad) & status.fill_last;
        cmd.round     = (state_reg == sha256_pkg::ST_ROUND);
        cmd.round_idx = round_reg;
        cmd.update    = (state_reg == sha256_pkg::ST_UPDATE);
        cmd.clear     = digest_valid & digest_ready & (part_reg == sha256_pkg::PART_LAST);
        cmd.part      = part_reg;
    end

    always_comb
    begin
        round_next       = cmd.round ? round_reg + 6'd1 : '0;
        part_next        = (digest_valid && digest_ready) ? part_reg + 2'd1 : part_reg;
        end_pending_next = end_pending_reg;
        final_next       = final_reg;
        if (accept && end_of_message)
            end_pending_next = 1'b1;
        if (cmd.push_pad && status.fill_last)
            final_next = status.len_byte;
        if (cmd.clear)
        begin
            end_pending_next = 1'b0;
            final_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= sha256_pkg::ST_IDLE;
            round_reg       <= '0;
            part_reg        <= '0;
            end_pending_reg <= 1'b0;
            final_reg       <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            round_reg       <= round_next;
            part_reg        <= part_next;
            end_pending_reg <= end_pending_next;
            final_reg       <= final_next;
        end
    end

    `SHS_ASSERT_NEVER(a_no_overlap, msg_ready && digest_valid, "intake and digest overlap")
    `SHS_ASSERT(a_round_start, (state_reg == sha256_pkg::ST_ROUND && $past(state_reg) != sha256_pkg::ST_ROUND) |-> (round_reg == 6'd0), "round count not zero at block start")
    `SHS_ASSERT(a_out_done, (digest_valid && digest_ready && part_reg == sha256_pkg::PART_LAST) |=> (state_reg == sha256_pkg::ST_IDLE && part_reg == 2'd0 && !final_reg), "digest end did not return to idle")

endmodule

// ===== design/sha256_stream_hash_top.sv =====
// SHA-256 stream hash top level: controller plus datapath.
// Uses sha256_pkg, sha256_ctrl and sha256_dp.
//
//  channel   handshake                     payload
//  msg       msg_valid / msg_ready         msg    (sha256_pkg::msg_item_t)
//  digest    digest_valid / digest_ready   digest (sha256_pkg::digest_item_t)
//
// A byte request is taken while idle; the request that fills a 64-byte block
// adds 64 rounds on the single round unit and one hash update.
// An end request adds 9 to 72 padding bytes (one byte per cycle outside
// the rounds) with one or two compressions, then four digest results.
// Reset is ready at once: no clearing pass. A stalled digest holds the block.
module sha256_stream_hash_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      msg_valid,
    output logic                      msg_ready,
    input  sha256_pkg::msg_item_t     msg,
    output logic                      digest_valid,
    input  logic                      digest_ready,
    output sha256_pkg::digest_item_t  digest
);

    sha256_pkg::dp_cmd_t    cmd;
    sha256_pkg::dp_status_t status;

    sha256_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .msg_valid      (msg_valid),
        .msg_ready      (msg_ready),
        .has_byte       (msg.has_byte),
        .end_of_message (msg.end_of_message),
        .digest_valid   (digest_valid),
        .digest_ready   (digest_ready),
        .status         (status),
        .cmd            (cmd)
    );

    sha256_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (msg.data_byte),
        .cmd       (cmd),
        .status    (status),
        .digest    (digest)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sha256_stream_hash_top: a SHA-256 model in the
// scoreboard class predicts the four digest parts of each message.
// Depends on sha256_pkg for the request and digest payload types.

module tb;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] SEED_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam int LEN_SLOT = 56;

    class digest_tracker;
        logic [31:0] hw [8];
        logic [7:0] blk [64];
        int unsigned fill;
        logic [63:0] nbytes;
        sha256_pkg::digest_item_t due [$];
        int unsigned errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            foreach (hw[i])
                hw[i] = SEED_H[i];
            fill = 0;
            nbytes = '0;
        endfunction

        function logic [31:0] rotr(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            logic [31:0] w [64];
            logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
            int i;
            for (i = 0; i < 16; i++)
                w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
            for (i = 16; i < 64; i++)
            begin
                s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
                s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
                w[i] = w[i-16] + s0 + w[i-7] + s1;
            end
            a = hw[0]; b = hw[1]; c = hw[2]; d = hw[3];
            e = hw[4]; f = hw[5]; g = hw[6]; h = hw[7];
            for (i = 0; i < 64; i++)
            begin
                t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                     + ROUND_K[i] + w[i];
                t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
                h = g; g = f; f = e; e = d + t1;
                d = c; c = b; b = a; a = t1 + t2;
            end
            hw[0] += a; hw[1] += b; hw[2] += c; hw[3] += d;
            hw[4] += e; hw[5] += f; hw[6] += g; hw[7] += h;
        endfunction

        function void push(logic [7:0] v);
            blk[fill] = v;
            fill++;
            if (fill == 64)
            begin
                compress();
                fill = 0;
            end
        endfunction

        // Note an accepted request; an end request queues the four digest parts.
        function void take_request(sha256_pkg::msg_item_t m);
            logic [63:0] bits;
            sha256_pkg::digest_item_t d;
            int k;
            if (m.has_byte)
            begin
                push(m.data_byte);
                nbytes++;
            end
            if (!m.end_of_message)
                return;
            bits = nbytes << 3;
            push(PAD_MARK);
            while (fill != LEN_SLOT)
                push(8'h00);
            for (k = 0; k < 8; k++)
                push(bits[63-8*k -: 8]);
            for (k = 0; k < 4; k++)
            begin
                d.digest_part = {hw[2*k], hw[2*k+1]};
                d.part_index = 2'(k);
                d.last_part = (k == 3);
                due.push_back(d);
            end
            restart();
        endfunction

        function void check_digest(sha256_pkg::digest_item_t got);
            sha256_pkg::digest_item_t want;
            if (due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected digest part: got %h idx %0d last %0b",
                             got.digest_part, got.part_index, got.last_part);
                return;
            end
            want = due.pop_front();
            if (got.digest_part !== want.digest_part || got.part_index !== want.part_index
                || got.last_part !== want.last_part)
            begin
                errors++;
                if (errors <= 10)
                    $display("digest mismatch: expected %h idx %0d last %0b, got %h idx %0d last %0b",
                             want.digest_part, want.part_index, want.last_part,
                             got.digest_part, got.part_index, got.last_part);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic msg_valid = 1'b0;
    logic msg_ready;
    sha256_pkg::msg_item_t msg = '0;
    logic digest_valid;
    logic digest_ready = 1'b0;
    sha256_pkg::digest_item_t digest;

    digest_tracker book;
    int idle_pct = 0;
    int stall_pct = 0;
    int sent;

    sha256_stream_hash_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_ready    (msg_ready),
        .msg          (msg),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .digest       (digest)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
        digest_ready <= ($urandom_range(99) >= stall_pct);

    // Requests and results are both taken here so their order at an edge is fixed.
    always @(posedge clk)
    begin
        if (rst_n && book != null)
        begin
            if (msg_valid && msg_ready)
                book.take_request(msg);
            if (digest_valid && digest_ready)
                book.check_digest(digest);
        end
    end

    task send_fields(logic [7:0] data, logic has, logic eom);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            msg_valid <= 1'b0;
            @(negedge clk);
        end
        msg_valid <= 1'b1;
        msg <= '{data_byte: data, has_byte: has, end_of_message: eom};
        @(posedge clk);
        while (!msg_ready)
            @(posedge clk);
        if (has || eom)
            sent++;
    endtask

    // len bytes, the last one optionally riding on the end request,
    // with bare requests sprinkled in as noise.
    task send_message(int len, bit end_with_byte, int noise_pct);
        int i;
        int plain;
        plain = (len > 0 && end_with_byte) ? len - 1 : len;
        for (i = 0; i < plain; i++)
        begin
            if ($urandom_range(99) < noise_pct)
                send_fields(8'($urandom_range(255)), 1'b0, 1'b0);
            send_fields(8'($urandom_range(255)), 1'b1, 1'b0);
        end
        send_fields(8'($urandom_range(255)), len > 0 && end_with_byte, 1'b1);
    endtask

    task wait_drained();
        @(negedge clk);
        msg_valid <= 1'b0;
        while (book.due.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int ph;
        int msgs;
        int len;
        book = new();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: bare request, empty message, single bytes, "abc", two bytes
        send_fields(8'h5a, 1'b0, 1'b0);
        send_fields(8'ha5, 1'b0, 1'b1);
        send_fields(8'h00, 1'b1, 1'b1);
        send_fields(8'hff, 1'b1, 1'b0);
        send_fields(8'h00, 1'b0, 1'b1);
        send_fields(8'h61, 1'b1, 1'b0);
        send_fields(8'h62, 1'b1, 1'b0);
        send_fields(8'hff, 1'b0, 1'b0);
        send_fields(8'h63, 1'b1, 1'b1);
        send_fields(8'h80, 1'b1, 1'b0);
        send_fields(8'h7f, 1'b1, 1'b1);
        wait_drained();

        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin idle_pct = 0; stall_pct = 0; end
                1: begin idle_pct = 80; stall_pct = 0; end
                2: begin idle_pct = 0; stall_pct = 80; end
                default: begin idle_pct = 13; stall_pct = 13; end
            endcase
            sent = 0;
            msgs = 0;
            if (ph == 0)
            begin
                // length fills past the length slot: padding needs an extra block
                send_message(56, 1'($urandom_range(1)), 5);
                msgs++;
            end
            while (sent < 28 || msgs < 3)
            begin
                if ($urandom_range(99) < 85)
                    len = $urandom_range(8);
                else
                    len = 54 + $urandom_range(11);
                send_message(len, 1'($urandom_range(1)), 8);
                msgs++;
            end
            wait_drained();
        end

        repeat (30) @(posedge clk);
        if (book.errors == 0 && book.due.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule
